FILE: rtl/chained_hash_set_core_defines.svh
`ifndef CHAINED_HASH_SET_CORE_DEFINES_SVH
`define CHAINED_HASH_SET_CORE_DEFINES_SVH

// Assertion helpers. Each one samples on the rising clock edge and is disabled during reset.
// The first form checks in the same cycle, and the second checks in the next cycle.

`define CHS_ASSERT_NOW(label, cond, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (chk)) \
      else $error(msg);

`define CHS_ASSERT_NEXT(label, cond, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (chk)) \
      else $error(msg);

`endif

FILE: rtl/chs_pkg.sv
package chs_pkg;

   localparam int BUCKETS    = 64;
   localparam int NODES      = 256;
   localparam int IDX_W      = $clog2(BUCKETS);
   localparam int SIZE_W     = IDX_W + 1;
   localparam int NODE_W     = $clog2(NODES);
   localparam int PTR_W      = NODE_W + 1;
   localparam int CNT_W      = $clog2(NODES + 1);
   localparam int KEY_W      = 31;
   localparam int DIV_STEPS  = (KEY_W + 1) / 2;
   localparam int DIV_SH_W   = 2 * DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // The null link marks the end of a chain and an empty bucket.
   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(NODES);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic              key_we;
      logic              link_we;
      logic [NODE_W-1:0] addr;
      logic [KEY_W-1:0]  key;
      logic [PTR_W-1:0]  link;
   } node_wr_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PTR_W-1:0] link;
   } node_rd_type;

endpackage

FILE: rtl/chained_hash_set_core.sv
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    req_kind, req_value
// rsp       out        rsp_valid / rsp_ready    rsp_present, rsp_stored, rsp_full_res,
//                                               rsp_node_total
// csr       in         csr_we (no wait)         csr_wdata (bucket count)
//
// For each word, the bucket modulo retires two dividend bits per cycle, and each visited
// chain node takes a registered node memory read and then a compare. A hit ends after its
// compare, a miss also visits the end of the chain, and a stored insert adds a node write.
// Reset is synchronous and empties the table at once through per-bucket valid bits, so there
// is no clearing pass. The block takes one word at a time, and a finished result waits in the
// output register, so the next word is taken while rsp is stalled.

`include "chained_hash_set_core_defines.svh"

module chained_hash_set_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [chs_pkg::KEY_W-1:0]     req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_present,
   output logic                          rsp_stored,
   output logic                          rsp_full_res,
   output logic [chs_pkg::CNT_W-1:0]     rsp_node_total,
   input  logic                          csr_we,
   input  logic [chs_pkg::SIZE_W-1:0]    csr_wdata
);
   import chs_pkg::*;

   // The sequencer visits these states for each word.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_DIV    = 8'b00000010,
      ST_HEAD   = 8'b00000100,
      ST_WALK   = 8'b00001000,
      ST_CMP    = 8'b00010000,
      ST_DECIDE = 8'b00100000,
      ST_ALLOC  = 8'b01000000,
      ST_DONE   = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] eff_size;
   logic              kind_ff, kind_in;
   logic [KEY_W-1:0]  value_ff, value_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  last_ff, last_in;
   logic              present_ff, present_in;
   logic              stored_ff, stored_in;
   logic              full_ff, full_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff;
   logic              rsp_present_ff, rsp_stored_ff, rsp_full_ff;
   logic [CNT_W-1:0]  rsp_total_ff;
   logic              load_rsp;

   // The bucket heads live in a small memory, and a valid bit per bucket stands in for the
   // empty marker until the bucket first gets a node.
   logic [PTR_W-1:0]  head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [PTR_W-1:0]  head_rd_ff;
   logic              head_hit_ff;
   logic              head_we;

   logic              div_start;
   logic              div_done;
   logic [IDX_W-1:0]  bucket;

   node_wr_type       node_wr;
   node_rd_type       node_rd;

   logic              rsp_flag_clash;
   logic              query_decide;
   logic              div_finish;

   // A bucket count of zero acts as one, and anything above the table acts as the full table.
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(BUCKETS)) begin
         eff_size = SIZE_W'(BUCKETS);
      end else begin
         eff_size = size_ff;
      end
   end

   chs_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_in),
      .divisor   (eff_size),
      .done      (div_done),
      .remainder (bucket)
   );

   chs_node_mem u_nodes (
      .clock (clock),
      .wr    (node_wr),
      .raddr (cur_ff[NODE_W-1:0]),
      .rd    (node_rd)
   );

   // Sequencer. The chain is walked from its head. The last node seen is kept so that a new
   // value can be appended at the tail. The append first links the new node from the tail or
   // from the bucket head, and then writes the node itself in the next cycle.
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      cur_in     = cur_ff;
      last_in    = last_ff;
      present_in = present_ff;
      stored_in  = stored_ff;
      full_in    = full_ff;
      count_in   = count_ff;
      node_wr    = '0;
      head_we    = 1'b0;
      load_rsp   = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               value_in   = req_value;
               present_in = 1'b0;
               stored_in  = 1'b0;
               full_in    = 1'b0;
               last_in    = NIL_PTR;
               div_start  = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cur_in   = head_hit_ff ? head_rd_ff : NIL_PTR;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cur_ff == NIL_PTR) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (node_rd.key == value_ff) begin
               present_in = 1'b1;
               state_in   = ST_DECIDE;
            end else begin
               last_in  = cur_ff;
               cur_in   = node_rd.link;
               state_in = ST_WALK;
            end
         end
         ST_DECIDE: begin
            if (kind_ff == KIND_INSERT && !present_ff) begin
               if (count_ff == CNT_W'(NODES)) begin
                  full_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  if (last_ff == NIL_PTR) begin
                     head_we = 1'b1;
                  end else begin
                     node_wr.link_we = 1'b1;
                     node_wr.addr    = last_ff[NODE_W-1:0];
                     node_wr.link    = PTR_W'(count_ff);
                  end
                  state_in = ST_ALLOC;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ALLOC: begin
            node_wr.key_we  = 1'b1;
            node_wr.link_we = 1'b1;
            node_wr.addr    = count_ff[NODE_W-1:0];
            node_wr.key     = value_ff;
            node_wr.link    = NIL_PTR;
            count_in        = count_ff + CNT_W'(1);
            stored_in       = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         size_ff  <= SIZE_W'(BUCKETS);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) size_ff <= csr_wdata;
      end
   end

   // These registers hold the working data of the word in flight.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      cur_ff     <= cur_in;
      last_ff    <= last_in;
      present_ff <= present_in;
      stored_ff  <= stored_in;
      full_ff    <= full_in;
   end

   // The bucket index from the modulo unit is held until the next word starts, so one registered
   // read each cycle serves ST_HEAD.
   always_ff @(posedge clock) begin
      if (head_we) head_mem[bucket] <= PTR_W'(count_ff);
      head_rd_ff  <= head_mem[bucket];
      head_hit_ff <= head_vld_ff[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (head_we) begin
         head_vld_ff[bucket] <= 1'b1;
      end
   end

   // The output register lets the result of one word wait here while the next word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_present_ff <= present_ff;
         rsp_stored_ff  <= stored_ff;
         rsp_full_ff    <= full_ff;
         rsp_total_ff   <= count_ff;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_stored     = rsp_stored_ff;
   assign rsp_full_res   = rsp_full_ff;
   assign rsp_node_total = rsp_total_ff;

   assign rsp_flag_clash = rsp_stored_ff && (rsp_present_ff || rsp_full_ff);
   assign query_decide   = (state_ff == ST_DECIDE) && (kind_ff == KIND_QUERY);
   assign div_finish     = (state_ff == ST_DIV) && div_done;

   `CHS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(NODES), "node count exceeds pool")
   `CHS_ASSERT_NOW(a_alloc_room, state_ff == ST_ALLOC, count_ff < CNT_W'(NODES), "pool full")
   `CHS_ASSERT_NOW(a_rsp_flags, rsp_valid, !rsp_flag_clash, "conflicting result flags")
   `CHS_ASSERT_NEXT(a_query_keeps_set, query_decide, $stable(count_ff), "query altered the set")
   `CHS_ASSERT_NEXT(a_head_after_div, div_finish, state_ff == ST_HEAD, "head read skipped")

endmodule

FILE: rtl/chs_mod_unit.sv
module chs_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [chs_pkg::KEY_W-1:0]    dividend,
   input  logic [chs_pkg::SIZE_W-1:0]   divisor,
   output logic                         done,
   output logic [chs_pkg::IDX_W-1:0]    remainder
);
   import chs_pkg::*;

   // One restoring step: shift one dividend bit into the partial remainder.
   function automatic logic [IDX_W-1:0] mod_bit(input logic [IDX_W-1:0] r,
                                                input logic b,
                                                input logic [SIZE_W-1:0] d);
      logic [SIZE_W-1:0] t;
      t = {r, b};
      if (t >= d) t = t - d;
      return t[IDX_W-1:0];
   endfunction

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_SH_W-1:0]  sh_ff, sh_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [IDX_W-1:0]     rem_one, rem_two;

   // Two dividend bits are retired per cycle, most significant first.
   assign rem_one = mod_bit(rem_ff, sh_ff[DIV_SH_W-1], divisor);
   assign rem_two = mod_bit(rem_one, sh_ff[DIV_SH_W-2], divisor);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = DIV_SH_W'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_two;
         sh_in  = {sh_ff[DIV_SH_W-3:0], 2'b00};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/chs_node_mem.sv
module chs_node_mem (
   input  logic                          clock,
   input  chs_pkg::node_wr_type          wr,
   input  logic [chs_pkg::NODE_W-1:0]    raddr,
   output chs_pkg::node_rd_type          rd
);
   import chs_pkg::*;

   logic [KEY_W-1:0] key_mem  [NODES];
   logic [PTR_W-1:0] link_mem [NODES];
   node_rd_type      rd_ff;

   // Entries are written when a node is allocated; no reset is needed.
   always_ff @(posedge clock) begin
      if (wr.key_we) key_mem[wr.addr] <= wr.key;
      if (wr.link_we) link_mem[wr.addr] <= wr.link;
      rd_ff.key  <= key_mem[raddr];
      rd_ff.link <= link_mem[raddr];
   end

   assign rd = rd_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for chained_hash_set_core, a set of non-negative keys kept in a hash table with
// separate chaining.
//
// A predictor in this module keeps its own copy of the buckets, the node pool and the bucket
// count register. When a request word is accepted, the predictor works out the response that
// the word must produce and queues it. The response side pops the oldest entry for every
// response word that is accepted and compares it field by field.
//
// Both sides idle at random between words, except during bursts where neither one does. One
// test holds the response side off for a long stretch. The core then holds one result in its
// output register and one finished word behind it, and stops taking request words.
module tb_top;
   import chs_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   // The slowest word walks a full pool in one chain.
   localparam int SETTLE_CYCLES = 600;
   localparam int RUN_LIMIT     = 1_500_000;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic             present;
      logic             stored;
      logic             full_res;
      logic [CNT_W-1:0] node_total;
   } set_answer_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_kind       = KIND_INSERT;
   logic [KEY_W-1:0]    req_value      = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic                rsp_present;
   logic                rsp_stored;
   logic                rsp_full_res;
   logic [CNT_W-1:0]    rsp_node_total;
   logic                csr_we         = 1'b0;
   logic [SIZE_W-1:0]   csr_wdata      = '0;

   // Predictor state. A link or a head equal to NODES marks the end of a chain.
   logic [KEY_W-1:0]    key_store [NODES];
   int                  link_store [NODES];
   int                  chain_head [BUCKETS];
   int                  nodes_held     = 0;
   logic [SIZE_W-1:0]   bucket_reg     = SIZE_W'(BUCKETS);

   set_answer_type      owed_answers [$];
   logic [KEY_W-1:0]    keys_sent [$];

   int                  fail_count     = 0;
   int                  cycle_count    = 0;
   int                  hold_cycles    = 0;
   int                  rsp_stall_left = 0;
   bit                  no_idle        = 1'b0;
   bit                  offer_held     = 1'b0;
   int                  next_gap       = 0;

   chained_hash_set_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_present    (rsp_present),
      .rsp_stored     (rsp_stored),
      .rsp_full_res   (rsp_full_res),
      .rsp_node_total (rsp_node_total),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Walks the chain of the key's bucket and appends the key at the tail when an insert misses
   // and the pool has room. The bucket count saturates to 1..BUCKETS. Nodes placed under an
   // older count stay where they are, so a lookup under a new count can miss them.
   function automatic set_answer_type insert_or_lookup(logic kind, logic [KEY_W-1:0] value);
      int             buckets_used;
      int             slot;
      int             cur;
      int             last;
      int             steps;
      set_answer_type ans;
      ans = '0;
      if (bucket_reg == '0) begin
         buckets_used = 1;
      end else if (bucket_reg > SIZE_W'(BUCKETS)) begin
         buckets_used = BUCKETS;
      end else begin
         buckets_used = int'(bucket_reg);
      end
      slot  = int'(value % KEY_W'(buckets_used));
      cur   = chain_head[slot];
      last  = NODES;
      steps = 0;
      while (cur < NODES && steps < NODES && !ans.present) begin
         if (key_store[cur] == value) begin
            ans.present = 1'b1;
         end else begin
            last = cur;
            cur  = link_store[cur];
            steps++;
         end
      end
      if (kind == KIND_INSERT && !ans.present) begin
         if (nodes_held >= NODES) begin
            ans.full_res = 1'b1;
         end else begin
            key_store[nodes_held]  = value;
            link_store[nodes_held] = NODES;
            if (last < NODES) begin
               link_store[last] = nodes_held;
            end else begin
               chain_head[slot] = nodes_held;
            end
            nodes_held++;
            ans.stored = 1'b1;
         end
      end
      ans.node_total = CNT_W'(nodes_held);
      return ans;
   endfunction

   // Idle cycles before the next word on either side. In a burst, neither side idles.
   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // Keys are drawn from earlier keys, so that hits and duplicates happen, from a small range
   // that crowds a few buckets, or from the full 31-bit range.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45 && keys_sent.size() != 0) begin
         return keys_sent[$urandom_range(0, keys_sent.size() - 1)];
      end else if (roll < 65) begin
         return KEY_W'($urandom_range(0, 300));
      end
      return KEY_W'($urandom);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Offers one request word. Valid stays high across back-to-back words. When a gap follows,
   // valid drops at the edge where the word is accepted.
   task automatic send_word(input logic kind, input logic [KEY_W-1:0] value);
      if (!offer_held) begin
         repeat (next_gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      owed_answers.push_back(insert_or_lookup(kind, value));
      keys_sent.push_back(value);
      next_gap = idle_draw();
      if (next_gap == 0) begin
         offer_held = 1'b1;
      end else begin
         offer_held = 1'b0;
         req_valid <= 1'b0;
      end
   endtask

   // Drops a valid that was kept high for a word that will not come.
   task automatic end_burst();
      if (offer_held) begin
         req_valid <= 1'b0;
         offer_held = 1'b0;
         next_gap   = 1;
      end
   endtask

   task automatic wait_idle();
      while (owed_answers.size() != 0) @(posedge clock);
   endtask

   // The register is written only when no word is outstanding.
   task automatic write_bucket_count(input logic [SIZE_W-1:0] count);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
      bucket_reg = count;
   endtask

   // These words use the bucket count from reset. They query an empty set, insert a key twice,
   // and use the smallest key, the largest key and two keys with alternating bits. The keys 0,
   // 64 and 128 build a chain of three nodes in one bucket, and 192 misses at its tail.
   task automatic test_directed_items();
      send_word(KIND_QUERY, '0);
      send_word(KIND_INSERT, '0);
      send_word(KIND_INSERT, '0);
      send_word(KIND_QUERY, '0);
      send_word(KIND_INSERT, '1);
      send_word(KIND_QUERY, '1);
      send_word(KIND_INSERT, KEY_W'(64));
      send_word(KIND_INSERT, KEY_W'(128));
      send_word(KIND_QUERY, KEY_W'(128));
      send_word(KIND_QUERY, KEY_W'(192));
      send_word(KIND_INSERT, 31'h2AAA_AAAA);
      send_word(KIND_INSERT, 31'h5555_5555);
      send_word(KIND_QUERY, 31'h5555_5555);
      send_word(KIND_INSERT, KEY_W'(1));
      send_word(KIND_INSERT, KEY_W'(128));
      end_burst();
      wait_idle();
   endtask

   // A count of zero acts as one bucket and a count above BUCKETS saturates. Keys stored under
   // the old count stay where they are, so some lookups miss them and some inserts add them a
   // second time.
   task automatic test_bucket_count_extremes();
      write_bucket_count('0);
      send_word(KIND_INSERT, KEY_W'(64));
      send_word(KIND_INSERT, KEY_W'(1));
      send_word(KIND_QUERY, '1);
      send_word(KIND_INSERT, KEY_W'(2));
      end_burst();
      wait_idle();
      write_bucket_count('1);
      send_word(KIND_QUERY, KEY_W'(1));
      send_word(KIND_INSERT, KEY_W'(65));
      send_word(KIND_QUERY, KEY_W'(2));
      end_burst();
      wait_idle();
      write_bucket_count(SIZE_W'(1));
      send_word(KIND_INSERT, KEY_W'(3));
      send_word(KIND_QUERY, KEY_W'(64));
      end_burst();
      wait_idle();
      write_bucket_count(SIZE_W'(BUCKETS));
   endtask

   // The response side holds off in its own process while request words keep coming. One result
   // waits in the output register, and a second word finishes behind it. After that, req_ready
   // must stay low until responses drain again.
   task automatic test_output_stall();
      hold_cycles <= HOLD_CYCLES;
      no_idle = 1'b1;
      repeat (8) send_word(KIND_INSERT, pick_key());
      no_idle = 1'b0;
      end_burst();
      wait_idle();
   endtask

   // Each phase uses a new bucket count, and some phases run as bursts with no idle cycles.
   task automatic test_random_mix();
      logic [SIZE_W-1:0] count;
      logic              kind;
      for (int phase = 0; phase < 6; phase++) begin
         count = (phase == 0) ? SIZE_W'(2) : SIZE_W'($urandom_range(1, 127));
         write_bucket_count(count);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (40) begin
            kind = ($urandom_range(0, 99) < 60) ? KIND_INSERT : KIND_QUERY;
            send_word(kind, pick_key());
         end
         end_burst();
         no_idle = 1'b0;
         wait_idle();
      end
   endtask

   // Fresh keys fill the node pool, so node_total reaches 256 and needs its top bit. Later
   // inserts of new keys are dropped and flagged. Inserts of keys already held still report
   // present without the flag.
   task automatic test_pool_exhaustion();
      logic [KEY_W-1:0] old_key;
      write_bucket_count(SIZE_W'(16));
      while (nodes_held < NODES) send_word(KIND_INSERT, KEY_W'($urandom));
      repeat (12) begin
         old_key = keys_sent[$urandom_range(0, keys_sent.size() - 1)];
         send_word(KIND_INSERT, KEY_W'($urandom));
         send_word(KIND_INSERT, old_key);
         send_word(KIND_QUERY, pick_key());
      end
      end_burst();
      wait_idle();
      write_bucket_count(SIZE_W'(1));
      send_word(KIND_INSERT, 31'h7FFF_FFFE);
      send_word(KIND_QUERY, '0);
      end_burst();
      wait_idle();
      write_bucket_count(SIZE_W'(BUCKETS));
   endtask

   // Response side. The predictor queued each expectation when its request word was accepted,
   // long before the word's response can appear, so the two processes never race on the queue.
   always @(posedge clock) begin : rsp_sink
      set_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_answers.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
         end else begin
            want = owed_answers.pop_front();
            check_field("present", int'(want.present), int'(rsp_present));
            check_field("stored", int'(want.stored), int'(rsp_stored));
            check_field("full_res", int'(want.full_res), int'(rsp_full_res));
            check_field("node_total", int'(want.node_total), int'(rsp_node_total));
         end
         rsp_stall_left = idle_draw();
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
      end
      rsp_ready <= (rsp_stall_left == 0) && (hold_cycles == 0);
   end

   // Counts down the long hold-off of the response side.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("chained_hash_set_core regression: fail");
         $finish;
      end
   end

   initial begin
      for (int b = 0; b < BUCKETS; b++) chain_head[b] = NODES;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_items();
      test_bucket_count_extremes();
      test_output_stall();
      test_random_mix();
      test_pool_exhaustion();
      end_burst();
      wait_idle();
      // Any response word that arrives late with nothing outstanding is flagged by rsp_sink.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("chained_hash_set_core regression: pass");
      end else begin
         $display("chained_hash_set_core regression: fail");
      end
      $finish;
   end

endmodule
